FILE: design/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on aclk, disabled during reset
`define CHK_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("port check failed");

// next-cycle implication on aclk, disabled during reset
`define CHK_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("port check failed");

`endif

FILE: design/sha1md_pkg.sv
// types, constants and helpers shared by the sha-1 digest unit
package sha1md_pkg;

    localparam int WORDS      = 16;
    localparam int IDX_W      = 4;
    localparam int ROUNDS     = 80;
    localparam int RND_W      = 7;
    localparam int TOTAL_W    = 55;
    localparam int DIGEST_N   = 5;
    localparam logic [IDX_W-1:0] LAST_IDX   = 4'd15;
    localparam logic [IDX_W-1:0] LEN_HI_IDX = 4'd14;
    localparam logic [IDX_W-1:0] LEN_LO_IDX = 4'd15;
    localparam logic [IDX_W-1:0] LEN_FIT_IDX = 4'd13;
    localparam logic [2:0] FULL_BYTES = 3'd4;
    localparam logic [2:0] LAST_DIGEST = 3'd4;

    // index 0 is the first chain word
    localparam logic [DIGEST_N-1:0][31:0] SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_result;
    } out_word_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      data;
    } mem_wr_t;

    typedef struct packed {
        logic start;
        logic reinit;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    // keep the n valid high bytes and put the marker right after them
    function automatic logic [31:0] mark_word(input logic [31:0] w, input logic [1:0] n);
        logic [31:0] r;
        begin
            unique case (n)
                2'd0: r = {PAD_MARK, 24'h000000};
                2'd1: r = {w[31:24], PAD_MARK, 16'h0000};
                2'd2: r = {w[31:16], PAD_MARK, 8'h00};
                2'd3: r = {w[31:8], PAD_MARK};
                default: r = {PAD_MARK, 24'h000000};
            endcase
            return r;
        end
    endfunction

endpackage

FILE: design/sha1md_wmem.sv
// 16-word block memory, one write port and two registered read ports
module sha1md_wmem (
    input  logic                         aclk,
    input  sha1md_pkg::mem_wr_t          wr,
    input  logic [sha1md_pkg::IDX_W-1:0] ra_addr,
    input  logic [sha1md_pkg::IDX_W-1:0] rb_addr,
    output logic [31:0]                  ra_data,
    output logic [31:0]                  rb_data
);

    logic [31:0] mem [sha1md_pkg::WORDS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

FILE: design/sha1md_core.sv
// sha-1 compression: one round per cycle, schedule kept in the block memory
module sha1md_core (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  sha1md_pkg::core_ctrl_t                   ctrl,
    output sha1md_pkg::core_stat_t                   stat,
    output logic [sha1md_pkg::DIGEST_N-1:0][31:0]    chain,
    output logic [sha1md_pkg::IDX_W-1:0]             ra_addr,
    output logic [sha1md_pkg::IDX_W-1:0]             rb_addr,
    input  logic [31:0]                              ra_data,
    input  logic [31:0]                              rb_data,
    output sha1md_pkg::mem_wr_t                      wr
);

    typedef enum logic [2:0] {
        CS_IDLE = 3'b001,
        CS_RND  = 3'b010,
        CS_ADD  = 3'b100
    } core_state_t;

    core_state_t cs_reg, cs_next;
    logic [sha1md_pkg::RND_W-1:0] rnd_reg, rnd_next, nxt;
    logic [sha1md_pkg::DIGEST_N-1:0][31:0] h_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    // wt of the last three rounds, and the delayed far read port
    logic [31:0] d1_reg, d2_reg, d3_reg, p1_reg, p2_reg;
    logic [31:0] f, k, wt, sx, tmp;

    assign chain = h_reg;
    assign stat.busy = (cs_reg != CS_IDLE);
    assign stat.done = (cs_reg == CS_ADD);

    // addresses for the next round; in idle they prefetch round 0
    assign nxt = (cs_reg == CS_RND) ? rnd_reg + 7'd1 : '0;
    assign rb_addr = (nxt < 7'(sha1md_pkg::WORDS)) ? nxt[3:0] : nxt[3:0] + 4'd8;
    assign ra_addr = nxt[3:0] + 4'd2;

    always_comb begin
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1md_pkg::K0;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1md_pkg::K1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1md_pkg::K2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1md_pkg::K3;
        end
    end

    assign sx  = d3_reg ^ rb_data ^ ra_data ^ p2_reg;
    assign wt  = (rnd_reg < 7'(sha1md_pkg::WORDS)) ? rb_data : {sx[30:0], sx[31]};
    assign tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;

    always_comb begin
        wr.en   = (cs_reg == CS_RND) && (rnd_reg >= 7'(sha1md_pkg::WORDS));
        wr.addr = rnd_reg[3:0];
        wr.data = wt;
    end

    always_comb begin
        cs_next  = cs_reg;
        rnd_next = rnd_reg;
        unique case (cs_reg)
            CS_IDLE: begin
                rnd_next = '0;
                if (ctrl.start) begin
                    cs_next = CS_RND;
                end
            end
            CS_RND: begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(sha1md_pkg::ROUNDS - 1)) begin
                    cs_next = CS_ADD;
                end
            end
            CS_ADD: begin
                cs_next = CS_IDLE;
            end
            default: begin
                cs_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cs_reg  <= CS_IDLE;
            rnd_reg <= '0;
        end else begin
            cs_reg  <= cs_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.reinit) begin
            h_reg <= sha1md_pkg::SHA1_IV;
        end else if (cs_reg == CS_ADD) begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cs_reg == CS_IDLE && ctrl.start) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (cs_reg == CS_RND) begin
            a_reg  <= tmp;
            b_reg  <= a_reg;
            c_reg  <= {b_reg[1:0], b_reg[31:2]};
            d_reg  <= c_reg;
            e_reg  <= d_reg;
            d1_reg <= wt;
            d2_reg <= d1_reg;
            d3_reg <= d2_reg;
            p1_reg <= ra_data;
            p2_reg <= p1_reg;
        end
    end

endmodule

FILE: design/sha1_message_digest_unit.sv
// sha-1 message digest unit: word buffering, padding control and digest output
//
// input channel s_valid/s_ready/s_data takes one big-endian 32-bit message word
// per transfer; last_word marks the final word, whose byte_count (0..4, larger
// values count as 4) gives its valid high-order bytes.
// result channel m_valid/m_ready/m_data gives the five digest words, index 0
// first, last_result set on the fifth; nothing comes out for other words.
// sixteen words fill a block, then the block is compressed (a start step, 80
// rounds on a single round unit, a chain add), during which s_ready is low and
// no new word is taken.
// the final word is followed by padding up to the end of the block, one or two
// compressions (the second after a further block of padding) and then the
// digest; one digest word leaves per cycle while m_ready is high.
// a stalled receiver holds the current digest word; input stays blocked
// until the fifth word is taken, then the chain returns to its initial value.
// reset (synchronous, active low) clears the fill count, block count and chain.
module sha1_message_digest_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1md_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1md_pkg::out_word_t m_data
);

    typedef enum logic [4:0] {
        ST_FILL  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_START = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [sha1md_pkg::IDX_W-1:0]   fill_reg, fill_next;
    logic [sha1md_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [sha1md_pkg::IDX_W-1:0]   pad_idx_reg, pad_idx_next;
    logic mark_pend_reg, mark_pend_next;
    logic pad_act_reg, pad_act_next;
    logic fin_blk_reg, fin_blk_next;
    logic [2:0] oidx_reg, oidx_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [31:0] mark_reg, mark_next;

    logic [2:0] n_sat;
    logic [6:0] bytes;
    logic fin_c;
    logic s_fire, m_fire;

    sha1md_pkg::mem_wr_t  wr_top, wr_core, wr_mem;
    sha1md_pkg::core_ctrl_t ctrl;
    sha1md_pkg::core_stat_t stat;
    logic [sha1md_pkg::DIGEST_N-1:0][31:0] chain;
    logic [sha1md_pkg::IDX_W-1:0] ra_addr, rb_addr;
    logic [31:0] ra_data, rb_data;

    assign s_ready = (state_reg == ST_FILL);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    assign m_data.digest_word = chain[oidx_reg];
    assign m_data.word_index  = oidx_reg;
    assign m_data.last_result = (oidx_reg == sha1md_pkg::LAST_DIGEST);

    assign n_sat = (s_data.byte_count > sha1md_pkg::FULL_BYTES) ?
                   sha1md_pkg::FULL_BYTES : s_data.byte_count;
    assign bytes = {1'b0, fill_reg, 2'b00} + {4'b0000, n_sat};
    // length block only if the marker leaves room for the two length words
    assign fin_c = mark_pend_reg ? (pad_idx_reg <= sha1md_pkg::LEN_FIT_IDX) : fin_blk_reg;

    assign ctrl.start  = (state_reg == ST_START);
    assign ctrl.reinit = m_fire && m_data.last_result;
    assign wr_mem = stat.busy ? wr_core : wr_top;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        pad_idx_next   = pad_idx_reg;
        mark_pend_next = mark_pend_reg;
        pad_act_next   = pad_act_reg;
        fin_blk_next   = fin_blk_reg;
        oidx_next      = oidx_reg;
        bitlen_next    = bitlen_reg;
        mark_next      = mark_reg;
        wr_top.en      = 1'b0;
        wr_top.addr    = fill_reg;
        wr_top.data    = s_data.message_word;

        unique case (state_reg)
            ST_FILL: begin
                if (s_fire) begin
                    if (!s_data.last_word || n_sat == sha1md_pkg::FULL_BYTES) begin
                        wr_top.en = 1'b1;
                        fill_next = fill_reg + 4'd1;
                        if (fill_reg == sha1md_pkg::LAST_IDX) begin
                            total_next = total_reg + 55'd1;
                            state_next = ST_START;
                        end
                    end
                    if (s_data.last_word) begin
                        bitlen_next    = {total_reg, 9'b0} + {54'b0, bytes, 3'b000};
                        pad_act_next   = 1'b1;
                        mark_pend_next = 1'b1;
                        fin_blk_next   = 1'b0;
                        if (n_sat == sha1md_pkg::FULL_BYTES) begin
                            mark_next    = sha1md_pkg::mark_word(s_data.message_word, 2'd0);
                            pad_idx_next = fill_reg + 4'd1;
                            if (fill_reg != sha1md_pkg::LAST_IDX) begin
                                state_next = ST_PAD;
                            end
                        end else begin
                            mark_next    = sha1md_pkg::mark_word(s_data.message_word,
                                                                 n_sat[1:0]);
                            pad_idx_next = fill_reg;
                            state_next   = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                wr_top.en   = 1'b1;
                wr_top.addr = pad_idx_reg;
                if (mark_pend_reg) begin
                    wr_top.data = mark_reg;
                end else if (fin_c && pad_idx_reg == sha1md_pkg::LEN_HI_IDX) begin
                    wr_top.data = bitlen_reg[63:32];
                end else if (fin_c && pad_idx_reg == sha1md_pkg::LEN_LO_IDX) begin
                    wr_top.data = bitlen_reg[31:0];
                end else begin
                    wr_top.data = '0;
                end
                mark_pend_next = 1'b0;
                fin_blk_next   = fin_c;
                pad_idx_next   = pad_idx_reg + 4'd1;
                if (pad_idx_reg == sha1md_pkg::LAST_IDX) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (stat.done) begin
                    if (!pad_act_reg) begin
                        state_next = ST_FILL;
                    end else if (fin_blk_reg) begin
                        oidx_next  = '0;
                        state_next = ST_OUT;
                    end else begin
                        // length did not fit: one more block of zeros and length
                        fin_blk_next = 1'b1;
                        pad_idx_next = '0;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    if (m_data.last_result) begin
                        fill_next    = '0;
                        total_next   = '0;
                        pad_act_next = 1'b0;
                        state_next   = ST_FILL;
                    end else begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            fill_reg      <= '0;
            total_reg     <= '0;
            pad_idx_reg   <= '0;
            mark_pend_reg <= 1'b0;
            pad_act_reg   <= 1'b0;
            fin_blk_reg   <= 1'b0;
            oidx_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            pad_idx_reg   <= pad_idx_next;
            mark_pend_reg <= mark_pend_next;
            pad_act_reg   <= pad_act_next;
            fin_blk_reg   <= fin_blk_next;
            oidx_reg      <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bitlen_reg <= bitlen_next;
        mark_reg   <= mark_next;
    end

    sha1md_wmem u_wmem (
        .aclk    (aclk),
        .wr      (wr_mem),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    sha1md_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .chain   (chain),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .ra_data (ra_data),
        .rb_data (rb_data),
        .wr      (wr_core)
    );

endmodule

FILE: design/sha1md_checker.sv
// port-level checks for the sha-1 digest unit, bound to the top level
`include "assert_macros.svh"

module sha1md_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input sha1md_pkg::in_word_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input sha1md_pkg::out_word_t m_data
);

    // input is blocked while digest words are being delivered
    `CHK_IMPLIES(a_no_in_during_out, m_valid, !s_ready)

    // a stalled digest word holds
    `CHK_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // digest words come in index order without gaps
    `CHK_NEXT(a_index_step, m_valid && m_ready && !m_data.last_result, m_valid && (m_data.word_index == $past(m_data.word_index) + 3'd1))

    // last flag exactly on the fifth word
    `CHK_IMPLIES(a_last_on_fifth, m_valid, m_data.last_result == (m_data.word_index == 3'd4))

    // after the fifth word the unit takes a new message
    `CHK_NEXT(a_back_to_input, m_valid && m_ready && m_data.last_result, s_ready && !m_valid)

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (.*);
